[design/chacha20_stream_cipher_top_macros.svh]
// Assertion macros shared by the ChaCha20 stream cipher modules.
// Each macro checks on the rising clock edge and is off while reset is low.
`ifndef CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH

// The condition holds, then the consequence holds in the same cycle.
`define CC20_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// The condition holds, then the consequence holds in the next cycle.
`define CC20_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

[design/cc20_pkg.sv]
// Shared types, constants and functions of the ChaCha20 stream cipher.
// No dependencies; the module files refer to it by scoped names.
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;

	// Register indexes of the configuration port.
	localparam logic [2:0] CFG_KEY0    = 3'd0;
	localparam logic [2:0] CFG_KEY1    = 3'd1;
	localparam logic [2:0] CFG_KEY2    = 3'd2;
	localparam logic [2:0] CFG_KEY3    = 3'd3;
	localparam logic [2:0] CFG_NONCE0  = 3'd4;
	localparam logic [2:0] CFG_NONCE12 = 3'd5;
	localparam logic [2:0] CFG_START   = 3'd6;

	// Item mode codes.
	localparam logic MODE_XOR       = 1'b0;
	localparam logic MODE_KEYSTREAM = 1'b1;

	// Default depth of the item queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Quarter-round step count: 10 double rounds, 8 steps each.
	localparam int ROUND_STEPS = 80;

	// The four constant words of the block state.
	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	typedef struct packed {
		logic [63:0] key_part_0;
		logic [63:0] key_part_1;
		logic [63:0] key_part_2;
		logic [63:0] key_part_3;
		logic [31:0] nonce_first_word;
		logic [63:0] nonce_tail;
		logic [31:0] start_counter;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       keystream;
	} item_t;

	typedef struct packed {
		logic start;
		logic abort;
		logic take;
	} core_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_sts_t;

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Starting block state from configuration and a block counter.
	function automatic block_t build_init(cfg_t cfg, word_t ctr);
		block_t b;
		b[0]  = SIGMA0;
		b[1]  = SIGMA1;
		b[2]  = SIGMA2;
		b[3]  = SIGMA3;
		b[4]  = cfg.key_part_0[31:0];
		b[5]  = cfg.key_part_0[63:32];
		b[6]  = cfg.key_part_1[31:0];
		b[7]  = cfg.key_part_1[63:32];
		b[8]  = cfg.key_part_2[31:0];
		b[9]  = cfg.key_part_2[63:32];
		b[10] = cfg.key_part_3[31:0];
		b[11] = cfg.key_part_3[63:32];
		b[12] = ctr;
		b[13] = cfg.nonce_first_word;
		b[14] = cfg.nonce_tail[31:0];
		b[15] = cfg.nonce_tail[63:32];
		return b;
	endfunction

endpackage

[design/cc20_front.sv]
// Front part: configuration registers and the input item queue.
// Depends on cc20_pkg.
module cc20_front #(
	parameter int QUEUE_DEPTH = cc20_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              mode,
	output cc20_pkg::cfg_t    cfg,
	output logic              cfg_load,
	output logic              item_valid,
	output cc20_pkg::item_t   item,
	input  logic              item_pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cc20_pkg::cfg_t  cfg_q;
	logic            cfg_load_q;
	cc20_pkg::item_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign cfg_load  = cfg_load_q;

	// Register writes; a write to a listed register also reloads the counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= '0;
			cfg_load_q <= 1'b0;
		end else begin
			cfg_load_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					cc20_pkg::CFG_KEY0: begin
						cfg_q.key_part_0 <= cfg_data;
						cfg_load_q       <= 1'b1;
					end
					cc20_pkg::CFG_KEY1: begin
						cfg_q.key_part_1 <= cfg_data;
						cfg_load_q       <= 1'b1;
					end
					cc20_pkg::CFG_KEY2: begin
						cfg_q.key_part_2 <= cfg_data;
						cfg_load_q       <= 1'b1;
					end
					cc20_pkg::CFG_KEY3: begin
						cfg_q.key_part_3 <= cfg_data;
						cfg_load_q       <= 1'b1;
					end
					cc20_pkg::CFG_NONCE0: begin
						cfg_q.nonce_first_word <= cfg_data[31:0];
						cfg_load_q             <= 1'b1;
					end
					cc20_pkg::CFG_NONCE12: begin
						cfg_q.nonce_tail <= cfg_data;
						cfg_load_q       <= 1'b1;
					end
					cc20_pkg::CFG_START: begin
						cfg_q.start_counter <= cfg_data[31:0];
						cfg_load_q          <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Queue handshake.
	assign in_stall   = (count_q == CW'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = mem_q[rd_ptr_q];

	// Queue storage; each item is tagged with its mode.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].data_byte <= data_byte;
			mem_q[wr_ptr_q].keystream <= (mode == cc20_pkg::MODE_KEYSTREAM);
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/cc20_core.sv]
// Block function: an iterative unit doing one quarter-round line per cycle.
// Depends on cc20_pkg and the assertion macro header.
`include "chacha20_stream_cipher_top_macros.svh"

module cc20_core (
	input  logic                clk,
	input  logic                arst_n,
	input  cc20_pkg::core_ctl_t ctl,
	input  cc20_pkg::word_t     start_ctr,
	input  cc20_pkg::cfg_t      cfg,
	output cc20_pkg::core_sts_t sts,
	output cc20_pkg::block_t    block
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINAL,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [6:0]       step_q;
	cc20_pkg::word_t  ctr_q;
	cc20_pkg::block_t w_q;
	cc20_pkg::block_t w_next;
	cc20_pkg::block_t init_w;
	logic [1:0]       line;
	logic             diag;

	assign line       = step_q[1:0];
	assign diag       = step_q[2];
	assign init_w     = cc20_pkg::build_init(cfg, ctr_q);
	assign sts.idle   = (state_q == ST_IDLE);
	assign sts.done   = (state_q == ST_DONE);
	assign block      = w_q;

	// One line of the four parallel quarter rounds, column or diagonal.
	always_comb begin
		logic [3:0]      ia;
		logic [3:0]      ib;
		logic [3:0]      ic;
		logic [3:0]      id;
		cc20_pkg::word_t s;
		w_next = w_q;
		for (int q = 0; q < 4; q++) begin
			ia = 4'(q);
			ib = 4'(4 + ((q + int'(diag)) & 3));
			ic = 4'(8 + ((q + 2 * int'(diag)) & 3));
			id = 4'(12 + ((q + 3 * int'(diag)) & 3));
			unique case (line)
				2'd0: begin
					s          = w_q[ia] + w_q[ib];
					w_next[ia] = s;
					w_next[id] = cc20_pkg::rotl(w_q[id] ^ s, 16);
				end
				2'd1: begin
					s          = w_q[ic] + w_q[id];
					w_next[ic] = s;
					w_next[ib] = cc20_pkg::rotl(w_q[ib] ^ s, 12);
				end
				2'd2: begin
					s          = w_q[ia] + w_q[ib];
					w_next[ia] = s;
					w_next[id] = cc20_pkg::rotl(w_q[id] ^ s, 8);
				end
				default: begin
					s          = w_q[ic] + w_q[id];
					w_next[ic] = s;
					w_next[ib] = cc20_pkg::rotl(w_q[ib] ^ s, 7);
				end
			endcase
		end
	end

	// Sequencer and working state; feed-forward happens in the final state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ctr_q   <= '0;
		end else if (ctl.abort) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						ctr_q   <= start_ctr;
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_q == 7'(cc20_pkg::ROUND_STEPS - 1)) begin
						state_q <= ST_FINAL;
					end
					step_q <= step_q + 1'b1;
				end
				ST_FINAL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ctl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working words: loaded at start, stepped while running, then fed forward.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ctl.start) begin
			w_q <= cc20_pkg::build_init(cfg, start_ctr);
		end else if (state_q == ST_RUN) begin
			w_q <= w_next;
		end else if (state_q == ST_FINAL) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= w_q[i] + init_w[i];
			end
		end
	end

	`CC20_ASSERT_SAME(a_step_range, clk, arst_n, state_q == ST_RUN, step_q < 7'(cc20_pkg::ROUND_STEPS), "round step out of range")
	`CC20_ASSERT_NEXT(a_abort_idle, clk, arst_n, ctl.abort, state_q == ST_IDLE, "abort did not return the core to idle")
	`CC20_ASSERT_NEXT(a_final_done, clk, arst_n, state_q == ST_FINAL && !ctl.abort, state_q == ST_DONE, "feed-forward not followed by done")

endmodule

[design/cc20_back.sv]
// Back part: keystream buffer, block counter, byte select and output register.
// Depends on cc20_pkg, cc20_core and the assertion macro header.
`include "chacha20_stream_cipher_top_macros.svh"

module cc20_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cc20_pkg::cfg_t  cfg,
	input  logic            cfg_load,
	input  logic            item_valid,
	input  cc20_pkg::item_t item,
	output logic            item_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte
);

	cc20_pkg::core_ctl_t ctl;
	cc20_pkg::core_sts_t sts;
	cc20_pkg::block_t    core_block;
	cc20_pkg::block_t    cur_q;
	cc20_pkg::word_t     ctr_q;
	cc20_pkg::word_t     ks_word;
	logic                cur_valid_q;
	logic [5:0]          pos_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic [7:0]          ks_byte;

	cc20_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.start_ctr (ctr_q),
		.cfg       (cfg),
		.sts       (sts),
		.block     (core_block)
	);

	// Core control: prefetch the next block whenever the core is free.
	assign ctl.abort = cfg_load;
	assign ctl.start = sts.idle && !cfg_load;
	assign ctl.take  = sts.done && !cur_valid_q && !cfg_load;

	// Byte select, little-endian within each word.
	assign ks_word  = cur_q[pos_q[5:2]];
	assign ks_byte  = ks_word[{pos_q[1:0], 3'b000} +: 8];
	assign item_pop = item_valid && cur_valid_q && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	// Buffer state and block counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			ctr_q       <= '0;
		end else if (cfg_load) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			ctr_q       <= cfg.start_counter;
		end else begin
			if (ctl.start) begin
				ctr_q <= ctr_q + 1'b1;
			end
			if (ctl.take) begin
				cur_valid_q <= 1'b1;
				pos_q       <= '0;
			end else if (item_pop) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == 6'd63) begin
					cur_valid_q <= 1'b0;
				end
			end
		end
	end

	// Buffer words arrive from the core in one copy.
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cur_q <= core_block;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output byte: keystream alone or XORed with the data byte.
	always_ff @(posedge clk) begin
		if (item_pop) begin
			out_byte_q <= item.keystream ? ks_byte : (ks_byte ^ item.data_byte);
		end
	end

	`CC20_ASSERT_SAME(a_start_idle, clk, arst_n, ctl.start, sts.idle && !sts.done, "block started while the core was busy")
	`CC20_ASSERT_SAME(a_take_empty, clk, arst_n, ctl.take, !cur_valid_q && !item_pop, "block copied over a live buffer")
	`CC20_ASSERT_NEXT(a_cfg_reload, clk, arst_n, cfg_load, !cur_valid_q && ctr_q == $past(cfg.start_counter), "configuration write did not reload")

endmodule

[design/chacha20_stream_cipher_top.sv]
// ChaCha20 stream cipher top level: one byte in, one byte out per item.
// Depends on cc20_pkg, cc20_front and cc20_back.
//
// Each item takes the next keystream byte, XORed with its data byte or, in
// keystream mode, alone; while the keystream buffer holds bytes and the
// output is not stalled, one item completes per cycle. A 64-byte block comes
// from the iterative core, which does one quarter-round line of four
// parallel quarter rounds per cycle; each block passes through the rounds,
// then a feed-forward step, then a handoff to the buffer. The next block is
// computed while the current one is consumed. After reset or any register
// write the first byte waits for its block. Register writes are taken at any
// time (ready is always high) and must be made while no items are in flight.
module chacha20_stream_cipher_top #(
	parameter int QUEUE_DEPTH = cc20_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte
);

	cc20_pkg::cfg_t  cfg;
	cc20_pkg::item_t item;
	logic            cfg_load;
	logic            item_valid;
	logic            item_pop;

	cc20_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.mode       (mode),
		.cfg        (cfg),
		.cfg_load   (cfg_load),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	cc20_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cfg_load   (cfg_load),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte)
	);

endmodule
